/* design/pui_pkg.sv */
// ----------------------------------------------------------------------------
// pui_pkg: shared types and constants of the pose integrator
// Fixed-point constants, the CORDIC arctangent table and the structs that
// travel along the rotation and division cell chains.
// ----------------------------------------------------------------------------
package pui_pkg;

	localparam logic signed [31:0] RAD2BAM_Q29 = 32'sd1367130551;
	localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic [15:0]        STEP_RESET  = 16'd6554;

	// Division chain widths, sized for the whole range of position fraction bits.
	localparam int DIVW = 51;
	localparam int ADW  = 38;

	function automatic logic [31:0] atan_bam(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'd536870912;
			1:  r = 32'd316933406;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10679838;
			7:  r = 32'd5340245;
			8:  r = 32'd2670163;
			9:  r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} pui_rot_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] hd;
		logic signed [15:0] v;
		logic signed [15:0] w;
		logic signed [33:0] vdt;
		logic [31:0]        b1;
		logic               f0;
		logic               f1;
	} pui_pay_t;

	typedef struct packed {
		logic [DIVW-1:0] n;
		logic [ADW-1:0]  rem;
		logic [DIVW-1:0] q;
	} pui_div_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] hd;
		logic signed [15:0] w;
		logic signed [39:0] sdx;
		logic signed [39:0] sdy;
		logic [15:0]        hout;
		logic               negx;
		logic               negy;
		logic [ADW-1:0]     ad;
	} pui_dpay_t;

endpackage

/* design/unicycle_pose_integrator_unit.sv */
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_unit: exact-arc unicycle pose step
// Advances x, y and heading over one step time under constant velocities.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on in_valid while in_stall is low and carries the pose and
// the velocity command. The result item leaves on out_valid and is taken in a
// cycle where out_stall is low. One item is accepted every cycle while in_stall is low.
// The pipeline is three angle stages, one CORDIC cell per stage, three
// product stages, a 51-cell restoring divider and the output register.
// While a result waits under out_stall the whole pipeline holds and in_stall
// rises, even when there are bubbles inside the pipeline.
// step_time is written through cfg_valid/cfg_data (cfg_ready is always high)
// and must only change while the block is idle.
// Reset empties the pipeline and sets step_time to 6554 (about 0.1 s).
// ----------------------------------------------------------------------------
module unicycle_pose_integrator_unit #(
	parameter int POS_FRAC_BITS   = 16,
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int TRIG_STAGES     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic signed [15:0] lin_vel,
	input  logic signed [15:0] ang_vel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic signed [15:0] next_heading,
	output logic               saturated
);
	import pui_pkg::*;

	localparam int HSH = 28 - ANGLE_FRAC_BITS;
	localparam int DSH = 30 - POS_FRAC_BITS;
	localparam int SSH = 58 - POS_FRAC_BITS;
	localparam int OSH = 60 - ANGLE_FRAC_BITS;

	logic        en;
	logic [15:0] step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	// Stage 1: velocity products and the start heading binary-angle product.
	logic               vld_s1;
	logic signed [31:0] px_s1, py_s1;
	logic signed [15:0] hd_s1, v_s1, w_s1;
	logic signed [33:0] vdt_s1, wdt_s1;
	logic signed [46:0] hp0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			hd_s1  <= heading;
			v_s1   <= lin_vel;
			w_s1   <= ang_vel;
			vdt_s1 <= 34'(lin_vel * $signed({1'b0, step_q}));
			wdt_s1 <= 34'(ang_vel * $signed({1'b0, step_q}));
			hp0_s1 <= 47'(heading * RAD2BAM_Q29);
		end
	end

	// Stage 2: end heading in radians, split into two partial products.
	logic signed [34:0] hw, ha1;
	logic signed [63:0] bp0;

	assign hw  = 35'(hd_s1) <<< HSH;
	assign ha1 = hw + 35'(wdt_s1);
	assign bp0 = (64'(hp0_s1) <<< HSH) + (64'sd1 <<< 28);

	logic               vld_s2;
	logic signed [31:0] px_s2, py_s2;
	logic signed [15:0] hd_s2, v_s2, w_s2;
	logic signed [33:0] vdt_s2;
	logic [31:0]        b0_s2;
	logic signed [48:0] ph_s2;
	logic signed [50:0] pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			hd_s2  <= hd_s1;
			v_s2   <= v_s1;
			w_s2   <= w_s1;
			vdt_s2 <= vdt_s1;
			b0_s2  <= bp0[60:29];
			ph_s2  <= 49'($signed(ha1[34:18]) * RAD2BAM_Q29);
			pl_s2  <= 51'($signed({1'b0, ha1[17:0]}) * RAD2BAM_Q29);
		end
	end

	// Stage 3: end binary angle and quadrant folding into the CORDIC range.
	logic signed [63:0] bp1;
	logic [31:0]        b1;

	assign bp1 = (64'(ph_s2) <<< 18) + 64'(pl_s2) + (64'sd1 <<< 28);
	assign b1  = bp1[60:29];

	function automatic logic need_flip(input logic [31:0] b);
		return ($signed(b) > 32'sd1073741824) || ($signed(b) < -32'sd1073741824);
	endfunction

	function automatic pui_rot_t prerot(input logic [31:0] b);
		pui_rot_t r;
		logic signed [33:0] z;
		z = 34'($signed(b));
		if (z > 34'sd1073741824) begin
			z = z - 34'sd2147483648;
		end else if (z < -34'sd1073741824) begin
			z = z + 34'sd2147483648;
		end
		r.x = GAIN_Q30;
		r.y = '0;
		r.z = z;
		return r;
	endfunction

	pui_pay_t pay_c [TRIG_STAGES+1];
	pui_rot_t r0_c  [TRIG_STAGES+1];
	pui_rot_t r1_c  [TRIG_STAGES+1];

	pui_pay_t pay_s3;
	pui_rot_t r0_s3, r1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_s3 <= '0;
		end else if (en) begin
			pay_s3.vld <= vld_s2;
			pay_s3.px  <= px_s2;
			pay_s3.py  <= py_s2;
			pay_s3.hd  <= hd_s2;
			pay_s3.v   <= v_s2;
			pay_s3.w   <= w_s2;
			pay_s3.vdt <= vdt_s2;
			pay_s3.b1  <= b1;
			pay_s3.f0  <= need_flip(b0_s2);
			pay_s3.f1  <= need_flip(b1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s3 <= prerot(b0_s2);
			r1_s3 <= prerot(b1);
		end
	end

	assign pay_c[0] = pay_s3;
	assign r0_c[0]  = r0_s3;
	assign r1_c[0]  = r1_s3;

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
		pui_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.pay_i  (pay_c[i]),
			.r0_i   (r0_c[i]),
			.r1_i   (r1_c[i]),
			.pay_o  (pay_c[i+1]),
			.r0_o   (r0_c[i+1]),
			.r1_o   (r1_c[i+1])
		);
	end

	pui_pay_t           pe;
	logic signed [33:0] c0, s0, c1, s1;

	assign pe = pay_c[TRIG_STAGES];
	assign c0 = pe.f0 ? -r0_c[TRIG_STAGES].x : r0_c[TRIG_STAGES].x;
	assign s0 = pe.f0 ? -r0_c[TRIG_STAGES].y : r0_c[TRIG_STAGES].y;
	assign c1 = pe.f1 ? -r1_c[TRIG_STAGES].x : r1_c[TRIG_STAGES].x;
	assign s1 = pe.f1 ? -r1_c[TRIG_STAGES].y : r1_c[TRIG_STAGES].y;

	// Product stage A: differences, split straight-line products, heading scale.
	logic               vld_a1;
	logic signed [31:0] px_a1, py_a1;
	logic signed [15:0] hd_a1, v_a1, w_a1;
	logic signed [34:0] ds_a1, dc_a1;
	logic signed [50:0] pxh_a1, pyh_a1;
	logic signed [51:0] pxl_a1, pyl_a1;
	logic signed [63:0] hpr_a1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a1 <= 1'b0;
		end else if (en) begin
			vld_a1 <= pe.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_a1  <= pe.px;
			py_a1  <= pe.py;
			hd_a1  <= pe.hd;
			v_a1   <= pe.v;
			w_a1   <= pe.w;
			ds_a1  <= 35'(s1) - 35'(s0);
			dc_a1  <= 35'(c0) - 35'(c1);
			pxh_a1 <= 51'(pe.vdt * $signed(c0[33:17]));
			pxl_a1 <= 52'(pe.vdt * $signed({1'b0, c0[16:0]}));
			pyh_a1 <= 51'(pe.vdt * $signed(s0[33:17]));
			pyl_a1 <= 52'(pe.vdt * $signed({1'b0, s0[16:0]}));
			hpr_a1 <= 64'($signed(pe.b1) * PI_Q29);
		end
	end

	// Product stage B: arc numerators, straight sums, rounded output heading.
	logic signed [63:0] hrnd;
	assign hrnd = (hpr_a1 + (64'sd1 <<< (OSH - 1))) >>> OSH;

	logic               vld_a2;
	logic signed [31:0] px_a2, py_a2;
	logic signed [15:0] hd_a2, w_a2;
	logic signed [50:0] nx_a2, ny_a2;
	logic signed [67:0] sx_a2, sy_a2;
	logic [15:0]        ho_a2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a2 <= 1'b0;
		end else if (en) begin
			vld_a2 <= vld_a1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_a2 <= px_a1;
			py_a2 <= py_a1;
			hd_a2 <= hd_a1;
			w_a2  <= w_a1;
			nx_a2 <= 51'(v_a1 * ds_a1);
			ny_a2 <= 51'(v_a1 * dc_a1);
			sx_a2 <= (68'(pxh_a1) <<< 17) + 68'(pxl_a1);
			sy_a2 <= (68'(pyh_a1) <<< 17) + 68'(pyl_a1);
			ho_a2 <= hrnd[15:0];
		end
	end

	// Product stage C: straight deltas rounded, divider operands as magnitudes.
	logic signed [67:0] tx, ty;
	logic [DIVW-1:0]    anx, any;
	logic [15:0]        absw;
	logic [ADW-1:0]     ad;

	assign tx   = (sx_a2 + (68'sd1 <<< (SSH - 1))) >>> SSH;
	assign ty   = (sy_a2 + (68'sd1 <<< (SSH - 1))) >>> SSH;
	assign anx  = nx_a2[50] ? DIVW'(-nx_a2) : DIVW'(nx_a2);
	assign any  = ny_a2[50] ? DIVW'(-ny_a2) : DIVW'(ny_a2);
	assign absw = w_a2[15] ? 16'(-w_a2) : 16'(w_a2);
	assign ad   = ADW'(absw) << DSH;

	pui_dpay_t dp_c [DIVW+1];
	pui_div_t  dx_c [DIVW+1];
	pui_div_t  dy_c [DIVW+1];

	pui_dpay_t dp_a3;
	pui_div_t  dx_a3, dy_a3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_a3 <= '0;
		end else if (en) begin
			dp_a3.vld  <= vld_a2;
			dp_a3.px   <= px_a2;
			dp_a3.py   <= py_a2;
			dp_a3.hd   <= hd_a2;
			dp_a3.w    <= w_a2;
			dp_a3.sdx  <= tx[39:0];
			dp_a3.sdy  <= ty[39:0];
			dp_a3.hout <= ho_a2;
			dp_a3.negx <= nx_a2[50] ^ w_a2[15];
			dp_a3.negy <= ny_a2[50] ^ w_a2[15];
			dp_a3.ad   <= ad;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_a3.n   <= anx + DIVW'(ad >> 1);
			dx_a3.rem <= '0;
			dx_a3.q   <= '0;
			dy_a3.n   <= any + DIVW'(ad >> 1);
			dy_a3.rem <= '0;
			dy_a3.q   <= '0;
		end
	end

	assign dp_c[0] = dp_a3;
	assign dx_c[0] = dx_a3;
	assign dy_c[0] = dy_a3;

	for (genvar j = 0; j < DIVW; j++) begin : g_div
		pui_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.pay_i  (dp_c[j]),
			.dx_i   (dx_c[j]),
			.dy_i   (dy_c[j]),
			.pay_o  (dp_c[j+1]),
			.dx_o   (dx_c[j+1]),
			.dy_o   (dy_c[j+1])
		);
	end

	// Output stage: pick straight or arc deltas, add and saturate.
	pui_dpay_t          de;
	logic signed [52:0] qx, qy, dx, dy;
	logic signed [53:0] sumx, sumy;
	logic               ovx, unx, ovy, uny;

	assign de   = dp_c[DIVW];
	assign qx   = $signed({2'b00, dx_c[DIVW].q});
	assign qy   = $signed({2'b00, dy_c[DIVW].q});
	assign dx   = (de.w == 16'sd0) ? 53'(de.sdx) : (de.negx ? -qx : qx);
	assign dy   = (de.w == 16'sd0) ? 53'(de.sdy) : (de.negy ? -qy : qy);
	assign sumx = 54'(de.px) + 54'(dx);
	assign sumy = 54'(de.py) + 54'(dy);
	assign ovx  = sumx > 54'sd2147483647;
	assign unx  = sumx < -54'sd2147483648;
	assign ovy  = sumy > 54'sd2147483647;
	assign uny  = sumy < -54'sd2147483648;

	logic               vld_q;
	logic signed [31:0] nx_q, ny_q;
	logic signed [15:0] nh_q;
	logic               sat_q;

	assign en = !(vld_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= de.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q  <= ovx ? 32'sh7FFFFFFF : (unx ? 32'sh80000000 : sumx[31:0]);
			ny_q  <= ovy ? 32'sh7FFFFFFF : (uny ? 32'sh80000000 : sumy[31:0]);
			nh_q  <= (de.w == 16'sd0) ? de.hd : $signed(de.hout);
			sat_q <= ovx | unx | ovy | uny;
		end
	end

	assign out_valid    = vld_q;
	assign next_x       = nx_q;
	assign next_y       = ny_q;
	assign next_heading = nh_q;
	assign saturated    = sat_q;

endmodule

/* design/pui_cordic_cell.sv */
// ----------------------------------------------------------------------------
// pui_cordic_cell: one CORDIC rotation stage
// Rotates the start and end heading vectors by one micro-angle and hands
// them, with the item payload, to the next cell.
// ----------------------------------------------------------------------------
module pui_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pui_pkg::pui_pay_t pay_i,
	input  pui_pkg::pui_rot_t r0_i,
	input  pui_pkg::pui_rot_t r1_i,
	output pui_pkg::pui_pay_t pay_o,
	output pui_pkg::pui_rot_t r0_o,
	output pui_pkg::pui_rot_t r1_o
);
	import pui_pkg::*;

	localparam logic signed [33:0] ATAN = $signed({2'b00, atan_bam(IDX)});

	function automatic pui_rot_t rotate(input pui_rot_t r);
		pui_rot_t o;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		xs = r.x >>> IDX;
		ys = r.y >>> IDX;
		if (r.z >= 0) begin
			o.x = r.x - ys;
			o.y = r.y + xs;
			o.z = r.z - ATAN;
		end else begin
			o.x = r.x + ys;
			o.y = r.y - xs;
			o.z = r.z + ATAN;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_o <= '0;
		end else if (en) begin
			pay_o <= pay_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_o <= rotate(r0_i);
			r1_o <= rotate(r1_i);
		end
	end

endmodule

/* design/pui_div_cell.sv */
// ----------------------------------------------------------------------------
// pui_div_cell: one restoring division step
// Produces one quotient bit for each of the x and y arc divisions and hands
// the partial remainders on to the next cell.
// ----------------------------------------------------------------------------
module pui_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  pui_pkg::pui_dpay_t pay_i,
	input  pui_pkg::pui_div_t  dx_i,
	input  pui_pkg::pui_div_t  dy_i,
	output pui_pkg::pui_dpay_t pay_o,
	output pui_pkg::pui_div_t  dx_o,
	output pui_pkg::pui_div_t  dy_o
);
	import pui_pkg::*;

	function automatic pui_div_t div_step(input pui_div_t d, input logic [ADW-1:0] ad);
		pui_div_t o;
		logic [ADW:0] trial;
		logic ge;
		trial = {d.rem, d.n[DIVW-1]};
		ge = (trial >= {1'b0, ad});
		o.rem = ge ? ADW'(trial - {1'b0, ad}) : trial[ADW-1:0];
		o.n = {d.n[DIVW-2:0], 1'b0};
		o.q = {d.q[DIVW-2:0], ge};
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_o <= '0;
		end else if (en) begin
			pay_o <= pay_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_o <= div_step(dx_i, pay_i.ad);
			dy_o <= div_step(dy_i, pay_i.ad);
		end
	end

endmodule
